// ===== hdl/dbls_pkg.sv =====
// Shared types and constants for the dual bounded LIFO stack unit.
// Holds opcode and status codes, field widths and parameter defaults.
// No dependencies.
package dbls_pkg;

  // Field widths fixed by the request and result formats
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Default sizing
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_NUM_STACKS  = 2;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SHOW = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage

// ===== hdl/dual_bounded_lifo_stack_unit.sv =====
// Dual bounded LIFO stack unit: request stream in, result stream out.
// Stack contents sit in one synchronous RAM; fill counts in flip-flops.
// Depends on dbls_pkg.
//
// Usage
//   Requests arrive on the s_axis channel: tuser carries the opcode (push,
//   pop, peek, show) and the stack select, tdata the value to push. Results
//   leave on the m_axis channel: tuser carries the status, tdata the value
//   read, tlast marks the final result of a request.
//   Push, pop and peek produce one result each; a new request is taken every
//   cycle while no show runs and the receiver keeps up. Show produces one
//   result per stored element, top first, one per cycle unless the receiver
//   stalls, and holds off new requests until its last read issues; an empty
//   stack gives a single empty status. A result is read from the RAM into the
//   read stage at its request transfer, then into the output register, from
//   which it shows on m_axis. One read port gives one element a cycle.
//   When the receiver stalls, results hold in the output register and the
//   read stage behind it; s_axis_tready drops once both are full.
//   A synchronous reset empties both stacks at once (fill counts to zero);
//   the RAM itself is not cleared and needs no clearing pass.
//   Only the stacks that the one-bit select can reach get storage; a select
//   naming no stack returns an empty status.
module dual_bounded_lifo_stack_unit
  import dbls_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_STACKS  = DEF_NUM_STACKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] push_value
  input  logic [OP_W:0]       s_axis_tuser,   // [1:0] opcode, [2] stack_select
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] read_value
  output logic [STAT_W-1:0]   m_axis_tuser,   // [1:0] status
  output logic                m_axis_tlast    // last_result
);

  // Stacks reachable by the one-bit select
  localparam int NREACH = (NUM_STACKS < 2) ? NUM_STACKS : 2;
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int IW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MDEPTH = NREACH * STACK_DEPTH;
  localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_t;

  state_t              state;
  logic                sh_sel;
  logic [IW-1:0]       sh_idx;
  logic [CW-1:0]       fill [NREACH];

  // Read stage, aligned with the RAM read data
  logic                v1;
  status_t             st1;
  logic                last1;
  logic                use1;
  logic [DATA_W-1:0]   rd_q;

  // Output register
  logic                out_valid;
  status_t             out_status;
  logic [DATA_W-1:0]   out_data;
  logic                out_last;

  logic [DATA_W-1:0]   mem [MDEPTH];

  logic                adv1;
  logic                s1_free;
  logic                acc;
  opcode_t             in_op;
  logic                in_sel;
  logic                sel_ok;
  logic [CW-1:0]       cnt;
  logic [IW-1:0]       top_idx;
  logic                full;
  logic                empty;
  logic                iss;
  logic                iss_rd;
  status_t             iss_status;
  logic                iss_last;
  logic                rd_sel;
  logic [IW-1:0]       rd_idx;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  // Flat RAM address of an entry in a stack
  function automatic logic [AW-1:0] addr_of(input logic sel, input logic [IW-1:0] idx);
    logic [AW-1:0] base;
    base = sel ? AW'(STACK_DEPTH) : '0;
    return base + AW'(idx);
  endfunction

  // Pipeline flow
  assign adv1          = v1 && (!out_valid || m_axis_tready);
  assign s1_free       = !v1 || adv1;
  assign s_axis_tready = (state == S_IDLE) && s1_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Decode the incoming request
  assign in_op   = opcode_t'(s_axis_tuser[OP_W-1:0]);
  assign in_sel  = s_axis_tuser[OP_W];
  assign sel_ok  = ({1'b0, in_sel} < 2'(NREACH));
  assign cnt     = sel_ok ? fill[in_sel] : '0;
  assign top_idx = IW'(cnt - CW'(1));
  assign full    = (cnt >= CW'(STACK_DEPTH));
  assign empty   = (cnt == '0);

  // Issue one result into the read stage per cycle while the stage is free
  always_comb begin
    iss        = 1'b0;
    iss_rd     = 1'b0;
    iss_status = ST_OK;
    iss_last   = 1'b1;
    rd_sel     = in_sel;
    rd_idx     = top_idx;
    wr_en      = 1'b0;
    if (state == S_SHOW) begin
      if (s1_free) begin
        iss      = 1'b1;
        iss_rd   = 1'b1;
        rd_sel   = sh_sel;
        rd_idx   = sh_idx;
        iss_last = (sh_idx == '0);
      end
    end else if (acc) begin
      iss = 1'b1;
      if (!sel_ok) begin
        iss_status = ST_EMPTY;
      end else begin
        case (in_op)
          OP_PUSH: begin
            if (full) iss_status = ST_OVERFLOW;
            else wr_en = 1'b1;
          end
          OP_POP, OP_PEEK: begin
            if (empty) iss_status = ST_EMPTY;
            else iss_rd = 1'b1;
          end
          OP_SHOW: begin
            if (empty) begin
              iss_status = ST_EMPTY;
            end else begin
              iss_rd   = 1'b1;
              iss_last = (cnt == CW'(1));
            end
          end
          default: iss_status = ST_EMPTY;
        endcase
      end
    end
  end

  assign rd_addr = addr_of(rd_sel, rd_idx);
  assign wr_addr = addr_of(in_sel, IW'(cnt));

  // Element RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    if (iss && iss_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Sequencer, fill counts, read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v1        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NREACH; i++) begin
        fill[i] <= '0;
      end
    end else begin
      // Advance fill counts on accepted push and pop
      if (acc && sel_ok) begin
        if (in_op == OP_PUSH && !full) fill[in_sel] <= cnt + CW'(1);
        if (in_op == OP_POP && !empty) fill[in_sel] <= cnt - CW'(1);
      end

      // Walk the stack top to bottom during show
      if (state == S_SHOW) begin
        if (iss) begin
          if (sh_idx == '0) state <= S_IDLE;
          else sh_idx <= sh_idx - IW'(1);
        end
      end else if (acc && sel_ok && in_op == OP_SHOW && cnt > CW'(1)) begin
        state  <= S_SHOW;
        sh_sel <= in_sel;
        sh_idx <= IW'(cnt - CW'(2));
      end

      // Load or drain the read stage
      if (iss) begin
        v1    <= 1'b1;
        st1   <= iss_status;
        last1 <= iss_last;
        use1  <= iss_rd;
      end else if (adv1) begin
        v1 <= 1'b0;
      end

      // Hold the result until the receiver takes it
      if (adv1) begin
        out_valid  <= 1'b1;
        out_status <= st1;
        out_data   <= use1 ? rd_q : '0;
        out_last   <= last1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  // Fill count of stack 0 never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[0] <= CW'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // An accepted push to stack 0 with room grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (acc && in_op == OP_PUSH && !in_sel && fill[0] < CW'(STACK_DEPTH))
    |=> fill[0] == $past(fill[0]) + CW'(1))
    else $error("push did not grow the stack");

  // No new request is taken while a show walks the stack
  a_show_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> !s_axis_tready)
    else $error("request taken during show");

  // Only show produces results that are not last, and those are all ok
  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == ST_OK))
    else $error("non-final result with error status");
`endif

endmodule
